[sv/hrhc_pkg.sv]
// package with request and result types, codes and text constants for the header checker
`timescale 1ns / 1ps
package hrhc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  status_code;
    logic [12:0] body_length;
    logic [12:0] body_offset;
  } result_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_VERSION     = 3'd1;
  localparam logic [2:0] ST_CODE        = 3'd2;
  localparam logic [2:0] ST_NO_END      = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
  localparam logic [2:0] ST_BODY_LONG   = 3'd5;
  localparam logic [2:0] ST_BODY_SHORT  = 3'd6;
  localparam logic [2:0] ST_CTYPE       = 3'd7;

  localparam logic [1:0] SLE_NONE    = 2'd0;
  localparam logic [1:0] SLE_VERSION = 2'd1;
  localparam logic [1:0] SLE_CODE    = 2'd2;
  localparam logic [1:0] SLE_NOCRLF  = 2'd3;

  localparam logic [2:0] PH_STATUS = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_NAME   = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_NEXT   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [4:0] TYPE_FAIL = 5'd31;
  localparam logic [4:0] LEN_NAME_LEN  = 5'd14;
  localparam logic [4:0] TYPE_NAME_LEN = 5'd12;
  localparam logic [4:0] JSON_LEN      = 5'd16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [23:0] CRLFCR  = 24'h0D0A0D;

  localparam logic [71:0]  VERSION_STR = "HTTP/1.1 ";
  localparam logic [111:0] LEN_NAME    = "content-length";
  localparam logic [95:0]  TYPE_NAME   = "content-type";
  localparam logic [127:0] JSON_TYPE   = "application/json";

  function automatic logic [7:0] version_char(input logic [3:0] i);
    return (i < 4'd9) ? VERSION_STR[8*(8-int'(i)) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] len_name_char(input logic [4:0] i);
    return (i < LEN_NAME_LEN) ? LEN_NAME[8*(13-int'(i)) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] type_name_char(input logic [4:0] i);
    return (i < TYPE_NAME_LEN) ? TYPE_NAME[8*(11-int'(i)) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] json_char(input logic [4:0] i);
    return (i < JSON_LEN) ? JSON_TYPE[8*(15-int'(i)) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

endpackage

[sv/http_response_header_checker.sv]
// top level: streaming http/1.1 response header checker
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   byte     | byte_valid/byte_stall  | byte_req: data_byte, last_byte
//   result   | result_valid/result_stall | result: status, code, length, offset
//
// one byte per cycle unless byte_stall; a last byte's result shows the cycle after it
// all parsing is one pass of logic from the state registers to the result register
// rst (synchronous) clears the parse state and empties the result register
// byte_stall is high only while a result is held and result_stall is high
`timescale 1ns / 1ps
module http_response_header_checker #(
  parameter int MAX_RESPONSE_LEN = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  hrhc_pkg::byte_req_t byte_req,
  output logic                result_valid,
  input  logic                result_stall,
  output hrhc_pkg::result_t   result
);

  localparam int LEN_W = $clog2(MAX_RESPONSE_LEN + 1);
  localparam int ACC_W = LEN_W + 4;
  localparam logic [23:0] COUNT_LIMIT = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]       phase;
    logic [4:0]       nidx;
    logic             lalive;
    logic             talive;
    logic             lfound;
    logic [LEN_W-1:0] lval;
    logic [1:0]       lphase;
    logic             lbad;
    logic             tfound;
    logic [4:0]       tidx;
    logic [1:0]       tphase;
  } line_t;

  function automatic line_t feed_length(input line_t s, input logic [7:0] c);
    line_t r;
    logic [ACC_W-1:0] acc;
    logic go;
    r = s;
    go = 1'b0;
    if (!s.lbad) begin
      if (s.lphase == 2'd0 || s.lphase == 2'd2) begin
        if (!hrhc_pkg::is_blank(c)) begin
          if (s.lphase == 2'd2 || !hrhc_pkg::is_digit(c)) begin
            r.lbad = 1'b1;
          end else begin
            r.lval = '0;
            r.lphase = 2'd1;
            go = 1'b1;
          end
        end
      end else if (hrhc_pkg::is_blank(c)) begin
        r.lphase = 2'd2;
      end else if (!hrhc_pkg::is_digit(c)) begin
        r.lbad = 1'b1;
      end else begin
        go = 1'b1;
      end
    end
    if (go) begin
      acc = ACC_W'(r.lval) * ACC_W'(10) + ACC_W'(c - "0");
      if (acc > ACC_W'(MAX_RESPONSE_LEN)) r.lbad = 1'b1;
      else r.lval = acc[LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic line_t feed_type(input line_t s, input logic [7:0] c);
    line_t r;
    r = s;
    if (s.tphase != 2'd3) begin
      if (c == hrhc_pkg::CH_SEMI) begin
        r.tphase = 2'd3;
      end else if (hrhc_pkg::is_blank(c)) begin
        if (s.tphase == 2'd1) r.tphase = 2'd2;
      end else if (s.tphase == 2'd2) begin
        r.tidx = hrhc_pkg::TYPE_FAIL;
        r.tphase = 2'd3;
      end else begin
        r.tphase = 2'd1;
        if (s.tidx < hrhc_pkg::JSON_LEN &&
            hrhc_pkg::to_lower(c) == hrhc_pkg::json_char(s.tidx)) begin
          r.tidx = s.tidx + 5'd1;
        end else begin
          r.tidx = hrhc_pkg::TYPE_FAIL;
        end
      end
    end
    return r;
  endfunction

  function automatic line_t feed_line(input line_t s, input logic [7:0] c);
    line_t r;
    logic len_hit;
    logic type_hit;
    logic [7:0] lc;
    r = s;
    lc = hrhc_pkg::to_lower(c);
    if (r.phase == hrhc_pkg::PH_FIRST || r.phase == hrhc_pkg::PH_NEXT) begin
      r.nidx = '0;
      r.lalive = 1'b1;
      r.talive = 1'b1;
      r.phase = hrhc_pkg::PH_NAME;
    end
    if (r.phase == hrhc_pkg::PH_NAME) begin
      if (c == hrhc_pkg::CH_COLON) begin
        len_hit = r.lalive && r.nidx == hrhc_pkg::LEN_NAME_LEN && !r.lfound;
        type_hit = r.talive && r.nidx == hrhc_pkg::TYPE_NAME_LEN && !r.tfound;
        r.lalive = len_hit;
        r.talive = type_hit;
        if (len_hit) begin
          r.lfound = 1'b1;
          r.lval = '0;
          r.lphase = 2'd0;
          r.lbad = 1'b0;
        end
        if (type_hit) begin
          r.tfound = 1'b1;
          r.tidx = '0;
          r.tphase = 2'd0;
        end
        r.phase = hrhc_pkg::PH_VALUE;
      end else begin
        if (r.nidx >= hrhc_pkg::LEN_NAME_LEN || lc != hrhc_pkg::len_name_char(r.nidx))
          r.lalive = 1'b0;
        if (r.nidx >= hrhc_pkg::TYPE_NAME_LEN || lc != hrhc_pkg::type_name_char(r.nidx))
          r.talive = 1'b0;
        if (r.nidx < 5'd31) r.nidx = r.nidx + 5'd1;
      end
    end else if (r.phase == hrhc_pkg::PH_VALUE) begin
      if (r.lalive) r = feed_length(r, c);
      if (r.talive) r = feed_type(r, c);
    end
    return r;
  endfunction

  logic [23:0] byte_position, byte_position_next;
  logic [23:0] recent_bytes, recent_bytes_next;
  logic [9:0]  status_code_value, status_code_value_next;
  logic [1:0]  status_line_error, status_line_error_next;
  logic        header_end_found, header_end_found_next;
  logic [23:0] header_end_position, header_end_position_next;
  logic [23:0] body_count, body_count_next;
  line_t       line, line_next;

  logic           accept;
  hrhc_pkg::result_t res_next;

  assign byte_stall = result_valid && result_stall;
  assign accept = byte_valid && !byte_stall;

  always_comb begin
    logic [7:0] c;
    logic [7:0] prev;
    logic [23:0] hep4;
    logic [23:0] lval_w;
    c = byte_req.data_byte;
    prev = recent_bytes[7:0];
    byte_position_next = byte_position;
    recent_bytes_next = recent_bytes;
    status_code_value_next = status_code_value;
    status_line_error_next = status_line_error;
    header_end_found_next = header_end_found;
    header_end_position_next = header_end_position;
    body_count_next = body_count;
    line_next = line;

    if (header_end_found) begin
      if (body_count < COUNT_LIMIT) body_count_next = body_count + 24'd1;
    end else begin
      if (byte_position < 24'd9) begin
        if (c != hrhc_pkg::version_char(byte_position[3:0]) &&
            status_line_error == hrhc_pkg::SLE_NONE)
          status_line_error_next = hrhc_pkg::SLE_VERSION;
      end else if (byte_position < 24'd12) begin
        if (hrhc_pkg::is_digit(c))
          status_code_value_next = status_code_value * 10'd10 + 10'(c - "0");
        else if (status_line_error == hrhc_pkg::SLE_NONE)
          status_line_error_next = hrhc_pkg::SLE_CODE;
      end else if (byte_position == 24'd12) begin
        if (c != hrhc_pkg::CH_SPACE && c != hrhc_pkg::CH_CR &&
            status_line_error == hrhc_pkg::SLE_NONE)
          status_line_error_next = hrhc_pkg::SLE_CODE;
      end

      if (prev == hrhc_pkg::CH_CR && c == hrhc_pkg::CH_LF) begin
        if (line_next.phase == hrhc_pkg::PH_STATUS) line_next.phase = hrhc_pkg::PH_FIRST;
        else if (line_next.phase == hrhc_pkg::PH_NAME || line_next.phase == hrhc_pkg::PH_VALUE)
          line_next.phase = hrhc_pkg::PH_NEXT;
        line_next.lalive = 1'b0;
        line_next.talive = 1'b0;
      end else begin
        // a held cr that did not start a line break is plain text
        if (prev == hrhc_pkg::CH_CR) line_next = feed_line(line_next, hrhc_pkg::CH_CR);
        if (c != hrhc_pkg::CH_CR) line_next = feed_line(line_next, c);
      end

      if (byte_position >= 24'd3 && recent_bytes == hrhc_pkg::CRLFCR &&
          c == hrhc_pkg::CH_LF) begin
        header_end_found_next = 1'b1;
        header_end_position_next = byte_position - 24'd3;
        if (line_next.phase == hrhc_pkg::PH_FIRST &&
            status_line_error_next == hrhc_pkg::SLE_NONE)
          status_line_error_next = hrhc_pkg::SLE_NOCRLF;
        line_next.phase = hrhc_pkg::PH_DONE;
      end
      recent_bytes_next = {recent_bytes[15:0], c};
    end
    if (byte_position < COUNT_LIMIT) byte_position_next = byte_position + 24'd1;

    // result for all bytes up to and including this one
    res_next = '0;
    hep4 = header_end_position_next + 24'd4;
    lval_w = 24'(line_next.lval);
    priority if (byte_position_next < 24'd12 ||
                 status_line_error_next == hrhc_pkg::SLE_VERSION) begin
      res_next.status = hrhc_pkg::ST_VERSION;
    end else if (byte_position_next <= 24'd12 ||
                 status_line_error_next == hrhc_pkg::SLE_CODE) begin
      res_next.status = hrhc_pkg::ST_CODE;
    end else if (!header_end_found_next) begin
      res_next.status = hrhc_pkg::ST_NO_END;
    end else if (status_line_error_next == hrhc_pkg::SLE_NOCRLF) begin
      res_next.status = hrhc_pkg::ST_CODE;
    end else begin
      res_next.body_offset = hep4[12:0];
      if (line_next.lfound && (line_next.lbad || line_next.lphase == 2'd0))
        res_next.status = hrhc_pkg::ST_BAD_LENGTH;
      else if (line_next.lfound && body_count_next > lval_w)
        res_next.status = hrhc_pkg::ST_BODY_LONG;
      else if (line_next.lfound && body_count_next < lval_w)
        res_next.status = hrhc_pkg::ST_BODY_SHORT;
      else if (line_next.lfound && lval_w != 24'd0 &&
               !(line_next.tfound && line_next.tidx == hrhc_pkg::JSON_LEN))
        res_next.status = hrhc_pkg::ST_CTYPE;
      else begin
        res_next.status = hrhc_pkg::ST_OK;
        res_next.status_code = status_code_value_next;
        res_next.body_length = line_next.lfound ? lval_w[12:0] : 13'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      recent_bytes <= '0;
      status_code_value <= '0;
      status_line_error <= hrhc_pkg::SLE_NONE;
      header_end_found <= 1'b0;
      header_end_position <= '0;
      body_count <= '0;
      line <= '{phase: hrhc_pkg::PH_STATUS, nidx: '0, lalive: 1'b1, talive: 1'b1,
                lfound: 1'b0, lval: '0, lphase: 2'd0, lbad: 1'b0, tfound: 1'b0,
                tidx: '0, tphase: 2'd0};
    end else if (accept) begin
      byte_position <= byte_position_next;
      recent_bytes <= recent_bytes_next;
      status_code_value <= status_code_value_next;
      status_line_error <= status_line_error_next;
      header_end_found <= header_end_found_next;
      header_end_position <= header_end_position_next;
      body_count <= body_count_next;
      line <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && byte_req.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_req.last_byte) result <= res_next;
  end

endmodule

[sv/hrhc_checker.sv]
// port-level checker for the header checker, with its bind
`timescale 1ns / 1ps
module hrhc_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_stall,
  input logic                result_valid,
  input logic                result_stall,
  input hrhc_pkg::result_t   result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    byte_stall == (result_valid && result_stall))
    else $error("byte stall without a held result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != hrhc_pkg::ST_OK |->
      result.status_code == 10'd0 && result.body_length == 13'd0)
    else $error("failed result carries code or length");

  a_early_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == hrhc_pkg::ST_VERSION ||
      result.status == hrhc_pkg::ST_CODE || result.status == hrhc_pkg::ST_NO_END) |->
      result.body_offset == 13'd0)
    else $error("offset set before header end");

endmodule

bind http_response_header_checker hrhc_checker u_hrhc_checker (
  .clk(clk),
  .rst(rst),
  .byte_stall(byte_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result(result)
);

[tb/sv/tb_http_response_header_checker.sv]
// testbench for the http response header checker: one streamed response, predicted per byte
`timescale 1ns / 1ps
module tb_http_response_header_checker;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  hrhc_pkg::byte_req_t byte_req = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  hrhc_pkg::result_t   result;

  http_response_header_checker uut (
    .clk(clk), .rst(rst), .byte_valid(byte_valid), .byte_stall(byte_stall),
    .byte_req(byte_req), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  localparam int MAX_LEN = 4096;
  localparam int SAT = 24'hFFFFFF;

  // predictor state
  int unsigned pos_cnt, window, code_val, line_err, hdr_end_pos, phase, name_idx;
  int unsigned len_val, len_phase, ctype_idx, ctype_phase, body_cnt;
  bit hdr_end, len_alive, ctype_alive, len_seen, len_bad, ctype_seen;

  string version_txt = "HTTP/1.1 ";
  string len_txt = "content-length";
  string ctype_txt = "content-type";
  string json_txt = "application/json";

  hrhc_pkg::result_t expected_results[$];
  int errors = 0;
  bit sender_idles = 1'b1;
  bit recv_idles = 1'b1;
  bit recv_hold = 1'b0;

  function automatic int unsigned lc(int unsigned c);
    return (c >= "A" && c <= "Z") ? c + 32 : c;
  endfunction

  function automatic bit digit(int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank(int unsigned c);
    return c == 32 || c == 9;
  endfunction

  function automatic void length_char(int unsigned c);
    int unsigned nxt;
    if (len_bad) return;
    if (len_phase == 0 || len_phase == 2) begin
      if (blank(c)) return;
      if (len_phase == 2 || !digit(c)) begin
        len_bad = 1;
        return;
      end
      len_val = 0;
      len_phase = 1;
    end else if (blank(c)) begin
      len_phase = 2;
      return;
    end else if (!digit(c)) begin
      len_bad = 1;
      return;
    end
    nxt = len_val * 10 + (c - "0");
    if (nxt > MAX_LEN) len_bad = 1;
    else len_val = nxt;
  endfunction

  function automatic void ctype_char(int unsigned c);
    if (ctype_phase == 3) return;
    if (c == ";") begin
      ctype_phase = 3;
      return;
    end
    if (blank(c)) begin
      if (ctype_phase == 1) ctype_phase = 2;
      return;
    end
    if (ctype_phase == 2) begin
      ctype_idx = hrhc_pkg::TYPE_FAIL;
      ctype_phase = 3;
      return;
    end
    ctype_phase = 1;
    if (ctype_idx < 16 && lc(c) == json_txt[ctype_idx]) ctype_idx++;
    else ctype_idx = hrhc_pkg::TYPE_FAIL;
  endfunction

  function automatic void header_char(int unsigned c);
    bit lhit, thit;
    if (phase == hrhc_pkg::PH_FIRST || phase == hrhc_pkg::PH_NEXT) begin
      name_idx = 0;
      len_alive = 1;
      ctype_alive = 1;
      phase = hrhc_pkg::PH_NAME;
    end
    if (phase == hrhc_pkg::PH_NAME) begin
      if (c == ":") begin
        lhit = len_alive && name_idx == 14 && !len_seen;
        thit = ctype_alive && name_idx == 12 && !ctype_seen;
        len_alive = lhit;
        ctype_alive = thit;
        if (lhit) begin
          len_seen = 1; len_val = 0; len_phase = 0; len_bad = 0;
        end
        if (thit) begin
          ctype_seen = 1; ctype_idx = 0; ctype_phase = 0;
        end
        phase = hrhc_pkg::PH_VALUE;
        return;
      end
      if (name_idx >= 14 || lc(c) != len_txt[name_idx]) len_alive = 0;
      if (name_idx >= 12 || lc(c) != ctype_txt[name_idx]) ctype_alive = 0;
      if (name_idx < 31) name_idx++;
    end else if (phase == hrhc_pkg::PH_VALUE) begin
      if (len_alive) length_char(c);
      if (ctype_alive) ctype_char(c);
    end
  endfunction

  // advance the parse by one byte; returns 1 with the status when the byte is marked last
  function automatic bit parse_byte(int unsigned c, bit last, output hrhc_pkg::result_t r);
    int unsigned p, st, blen, offs, cd;
    p = pos_cnt;
    r = '0;
    if (hdr_end) begin
      if (body_cnt < SAT) body_cnt++;
    end else begin
      if (p < 9) begin
        if (c != version_txt[p] && line_err == hrhc_pkg::SLE_NONE)
          line_err = hrhc_pkg::SLE_VERSION;
      end else if (p < 12) begin
        if (digit(c)) code_val = (code_val * 10 + (c - "0")) & 10'h3FF;
        else if (line_err == hrhc_pkg::SLE_NONE) line_err = hrhc_pkg::SLE_CODE;
      end else if (p == 12) begin
        if (c != 32 && c != 13 && line_err == hrhc_pkg::SLE_NONE)
          line_err = hrhc_pkg::SLE_CODE;
      end
      if ((window & 8'hFF) == 13 && c == 10) begin
        if (phase == hrhc_pkg::PH_STATUS) phase = hrhc_pkg::PH_FIRST;
        else if (phase == hrhc_pkg::PH_NAME || phase == hrhc_pkg::PH_VALUE)
          phase = hrhc_pkg::PH_NEXT;
        len_alive = 0;
        ctype_alive = 0;
      end else begin
        if ((window & 8'hFF) == 13) header_char(13);
        if (c != 13) header_char(c);
      end
      if (p >= 3 && window == hrhc_pkg::CRLFCR && c == 10) begin
        hdr_end = 1;
        hdr_end_pos = p - 3;
        if (phase == hrhc_pkg::PH_FIRST && line_err == hrhc_pkg::SLE_NONE)
          line_err = hrhc_pkg::SLE_NOCRLF;
        phase = hrhc_pkg::PH_DONE;
      end
      window = ((window << 8) | c) & 24'hFFFFFF;
    end
    if (pos_cnt < SAT) pos_cnt++;
    if (!last) return 0;
    st = hrhc_pkg::ST_OK; blen = 0; cd = 0; offs = 0;
    if (pos_cnt < 12 || line_err == hrhc_pkg::SLE_VERSION) st = hrhc_pkg::ST_VERSION;
    else if (pos_cnt <= 12 || line_err == hrhc_pkg::SLE_CODE) st = hrhc_pkg::ST_CODE;
    else if (!hdr_end) st = hrhc_pkg::ST_NO_END;
    else if (line_err == hrhc_pkg::SLE_NOCRLF) st = hrhc_pkg::ST_CODE;
    else begin
      offs = hdr_end_pos + 4;
      if (len_seen) begin
        if (len_bad || len_phase == 0) st = hrhc_pkg::ST_BAD_LENGTH;
        else if (body_cnt > len_val) st = hrhc_pkg::ST_BODY_LONG;
        else if (body_cnt < len_val) st = hrhc_pkg::ST_BODY_SHORT;
        else blen = len_val;
      end
      if (st == hrhc_pkg::ST_OK && blen > 0 && !(ctype_seen && ctype_idx == 16))
        st = hrhc_pkg::ST_CTYPE;
      if (st != hrhc_pkg::ST_OK) blen = 0;
      else cd = code_val;
    end
    r.status = st[2:0];
    r.status_code = cd[9:0];
    r.body_length = blen[12:0];
    r.body_offset = offs[12:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_byte(logic [7:0] c, logic last);
    hrhc_pkg::result_t r;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_req.data_byte <= c;
    byte_req.last_byte <= last;
    do @(posedge clk); while (byte_stall);
    if (parse_byte(c, last, r)) expected_results.push_back(r);
  endtask

  task automatic send_text(string s, int mark_at = -1);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == mark_at);
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    hrhc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", result.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) report_mismatch("status", result.status, want.status);
        if (result.status_code !== want.status_code)
          report_mismatch("status_code", result.status_code, want.status_code);
        if (result.body_length !== want.body_length)
          report_mismatch("body_length", result.body_length, want.body_length);
        if (result.body_offset !== want.body_offset)
          report_mismatch("body_offset", result.body_offset, want.body_offset);
      end
    end
  end

  // receiver stall: random bursts, or a long hold when asked
  always @(posedge clk) begin
    int unsigned hold_cnt;
    if (recv_hold) begin
      result_stall <= 1'b1;
      hold_cnt = 0;
      while (hold_cnt < 60) begin
        @(posedge clk);
        hold_cnt++;
      end
      recv_hold = 1'b0;
      result_stall <= 1'b0;
    end else if (recv_idles && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  task automatic test_status_line();
    send_text("HTTP", 3);           // too short for a status line
    send_text("/1.1 200", 7);       // exactly twelve bytes
    send_text(" OK\r\n", 1);        // status line still open
  endtask

  task automatic test_directed_headers();
    send_text("content-LENGTH: \t 12 \r\n");
    send_text("X-Cr: lone\rcr\r\n", 4);
    send_text("Content-Type:  Application/JSON ; charset=utf-8\r\n");
    send_text("Content-Length: 99\r\n");
    send_text("CONTENT-TYPE: text/plain\r\n");
  endtask

  task automatic test_random_headers();
    string names[6] = '{"Content-Length", "content-typE", "Content-Lengthx", "Conten",
                        "Host", "content-type2"};
    int n;
    logic [7:0] c;
    for (int l = 0; l < 12; l++) begin
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(33, 126)); while (c == ":");
          send_byte(c, $urandom_range(0, 7) == 0);
        end
      end else begin
        send_text(names[$urandom_range(0, 5)]);
      end
      send_byte(":", 1'b0);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: c = 8'("0" + $urandom_range(0, 9));
          1: c = ($urandom_range(0, 1) != 0) ? 8'h20 : 8'h09;
          default: do c = 8'($urandom_range(0, 255)); while (c == 8'h0A);
        endcase
        send_byte(c, $urandom_range(0, 9) == 0);
      end
      send_text("\r\n");
    end
    send_text("\r\n", 1);            // closes the headers
  endtask

  task automatic test_body_boundary();
    send_text("abcd", 3);            // body short
    send_text("efghijkl", 7);        // body exact
    send_byte(8'h0A, 1'b1);          // body long
  endtask

  task automatic test_receiver_hold();
    recv_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_sender_pause();
    drain();
  endtask

  task automatic test_random_body(int count, bit quiet);
    sender_idles = !quiet;
    recv_idles = !quiet;
    for (int i = 0; i < count; i++)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_status_line();
    test_directed_headers();
    test_random_headers();
    test_body_boundary();
    test_receiver_hold();
    test_sender_pause();
    test_random_body(360, 1'b0);
    test_random_body(120, 1'b1);
    drain();
    repeat (5) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("http_response_header_checker test passed");
    end else begin
      $display("http_response_header_checker test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("http_response_header_checker test failed");
    $finish;
  end

endmodule
